@@ hdl/bdq_pkg.sv @@
`timescale 1ns / 1ps

package bdq_pkg;

  // default number of entries held
  localparam int unsigned DefaultDepth = 64;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_DELETE_ALL = 3'd4;
  localparam logic [2:0] REQ_SIZE       = 3'd5;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // incoming request
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  // outgoing result
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] popped_byte;
    logic [6:0] removed_count;
    logic [6:0] occupancy_out;
  } rsp_t;

  // what every cell of the row does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,     // keep own byte
    CELL_SHR,      // take left neighbour, the first cell takes the broadcast byte
    CELL_SHL,      // take right neighbour
    CELL_PUT,      // addressed cell takes the broadcast byte
    CELL_SHL_PUT   // addressed cell takes the broadcast byte, the others shift left
  } cell_cmd_e;

  // broadcast control for the row
  typedef struct packed {
    cell_cmd_e  cmd;
    logic [7:0] data;
  } cell_ctl_t;

endpackage

@@ hdl/bdq_cell.sv @@
`timescale 1ns / 1ps

module bdq_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IDXW = 6
) (
  input  logic                  clk_i,
  input  bdq_pkg::cell_ctl_t    ctl_i,
  input  logic [IDXW-1:0]       tgt_i,
  input  logic [7:0]            left_i,
  input  logic [7:0]            right_i,
  output logic [7:0]            data_o,
  output logic [7:0]            tap_o
);

  localparam logic [IDXW-1:0] MyIdx = IDXW'(IDX);

  logic [7:0] data_q;
  logic [7:0] data_d;
  logic       hit;

  assign hit = (tgt_i == MyIdx);

  // next byte held by this cell
  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      bdq_pkg::CELL_SHR:     data_d = left_i;
      bdq_pkg::CELL_SHL:     data_d = right_i;
      bdq_pkg::CELL_PUT:     data_d = hit ? ctl_i.data : data_q;
      bdq_pkg::CELL_SHL_PUT: data_d = hit ? ctl_i.data : right_i;
      default:               data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // addressed cell shows its byte, the others show zero
  assign tap_o  = hit ? data_q : 8'd0;

endmodule

@@ hdl/byte_deque_with_delete_all.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue of bytes held in a row of DEPTH cells, front
// entry always in the first cell.
// Request channel: in_valid_i / in_stall_o carrying bdq_pkg::req_t
// (push front, push back, pop front, pop back, delete all, size query).
// Result channel: out_valid_o / out_stall_i carrying bdq_pkg::rsp_t, one
// result per request, in request order.
// For push, pop and size requests the row shifts or one cell is written
// at the acceptance edge and the result is valid in the next cycle, so
// such requests can follow each other every cycle while results are taken.
// Delete all walks the held entries one per cycle through the first cell,
// writing kept bytes back at the tail; the result is registered at the
// end of the walk, and no request is taken meanwhile.
// A full push is dropped with status full, a pop on an empty queue gives
// status empty and a zero byte.
// Reset empties the queue and the result register; cell contents are
// left as they are and are never read before being written.
// While the result register holds an untaken result and the receiver
// stalls, in_stall_o is raised; the result holds steady until taken.

module byte_deque_with_delete_all #(
  parameter int unsigned DEPTH = bdq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bdq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bdq_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic              st_q, st_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [CW-1:0]     left_q, left_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [7:0]        key_q, key_d;
  logic              out_valid_q, out_valid_d;
  bdq_pkg::rsp_t     rsp_q, rsp_d;

  logic              full, empty, out_free, in_acc, walk_step, walk_done, keep;
  logic [7:0]        head;
  logic [7:0]        back_byte;
  logic [IW-1:0]     tgt;
  bdq_pkg::cell_ctl_t ctl;

  logic [7:0] cell_data [DEPTH];
  logic [7:0] cell_tap  [DEPTH];

  // handshake
  assign full       = (occ_q == CW'(DEPTH));
  assign empty      = (occ_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign walk_step  = (st_q == ST_WALK) && (left_q != '0);
  assign walk_done  = (st_q == ST_WALK) && (left_q == '0) && out_free;
  assign head       = cell_data[0];
  assign keep       = (head != key_q);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] left_nb, right_nb;
    if (i == 0) begin : g_first
      assign left_nb = ctl.data;
    end else begin : g_mid
      assign left_nb = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_nb = ctl.data;
    end else begin : g_inner
      assign right_nb = cell_data[i+1];
    end
    bdq_cell #(
      .IDX  (i),
      .IDXW (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .tgt_i   (tgt),
      .left_i  (left_nb),
      .right_i (right_nb),
      .data_o  (cell_data[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // byte of the back entry, gathered from the addressed cell
  always_comb begin
    back_byte = 8'd0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      back_byte = back_byte | cell_tap[i];
    end
  end

  // row control
  always_comb begin
    ctl.cmd  = bdq_pkg::CELL_HOLD;
    ctl.data = in_req_i.data_byte;
    tgt      = IW'(occ_q - CW'(1));
    if (in_acc) begin
      unique case (in_req_i.req_type)
        bdq_pkg::REQ_PUSH_FRONT: begin
          if (!full) ctl.cmd = bdq_pkg::CELL_SHR;
        end
        bdq_pkg::REQ_PUSH_BACK: begin
          tgt = IW'(occ_q);
          if (!full) ctl.cmd = bdq_pkg::CELL_PUT;
        end
        bdq_pkg::REQ_POP_FRONT: begin
          if (!empty) ctl.cmd = bdq_pkg::CELL_SHL;
        end
        default: begin
          ctl.cmd = bdq_pkg::CELL_HOLD;
        end
      endcase
    end else if (walk_step) begin
      ctl.data = head;
      ctl.cmd  = keep ? bdq_pkg::CELL_SHL_PUT : bdq_pkg::CELL_SHL;
    end
  end

  // control state and result register
  always_comb begin
    st_d        = st_q;
    occ_d       = occ_q;
    left_d      = left_q;
    rem_d       = rem_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    rsp_d       = rsp_q;
    if (in_acc) begin
      rsp_d.status        = bdq_pkg::STATUS_OK;
      rsp_d.popped_byte   = 8'd0;
      rsp_d.removed_count = 7'd0;
      out_valid_d         = 1'b1;
      unique case (in_req_i.req_type)
        bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
          if (full) rsp_d.status = bdq_pkg::STATUS_FULL;
          else      occ_d = occ_q + CW'(1);
        end
        bdq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            rsp_d.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            rsp_d.popped_byte = head;
            occ_d             = occ_q - CW'(1);
          end
        end
        bdq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            rsp_d.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            rsp_d.popped_byte = back_byte;
            occ_d             = occ_q - CW'(1);
          end
        end
        bdq_pkg::REQ_DELETE_ALL: begin
          out_valid_d = 1'b0;
          st_d        = ST_WALK;
          left_d      = occ_q;
          rem_d       = '0;
          key_d       = in_req_i.data_byte;
        end
        default: begin
          rsp_d.status = bdq_pkg::STATUS_OK;
        end
      endcase
      rsp_d.occupancy_out = 7'(occ_d);
    end else if (walk_step) begin
      left_d = left_q - CW'(1);
      if (!keep) begin
        occ_d = occ_q - CW'(1);
        rem_d = rem_q + CW'(1);
      end
    end else if (walk_done) begin
      st_d                = ST_IDLE;
      out_valid_d         = 1'b1;
      rsp_d.status        = bdq_pkg::STATUS_OK;
      rsp_d.popped_byte   = 8'd0;
      rsp_d.removed_count = 7'(rem_q);
      rsp_d.occupancy_out = 7'(occ_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      occ_q       <= '0;
      left_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      occ_q       <= occ_d;
      left_q      <= left_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ tb/deque_result_checker.sv @@
`timescale 1ns / 1ps

module deque_result_checker #(
  parameter int unsigned DEPTH = bdq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_stall_i,
  input  bdq_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_stall_i,
  input  bdq_pkg::rsp_t rsp_i,
  output int unsigned   error_count_o,
  output int unsigned   pending_count_o
);

  // shadow copy of the queue
  logic [7:0]  held_bytes [DEPTH];
  int unsigned front_pos;
  int unsigned held_count;

  // results owed by the block, oldest first
  bdq_pkg::rsp_t predicted_rsp_q [$];
  bdq_pkg::rsp_t oldest_rsp;

  initial begin
    error_count_o   = 0;
    pending_count_o = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    error_count_o++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s mismatch: got %0d, want %0d", field, got, want));
    end
  endtask

  // apply one request to the shadow queue and return the result it owes
  function automatic bdq_pkg::rsp_t apply_request(input bdq_pkg::req_t req);
    bdq_pkg::rsp_t rsp;
    int unsigned   keep;
    logic [7:0]    b;
    rsp = '0;
    case (req.req_type)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (held_count >= DEPTH) begin
          rsp.status = bdq_pkg::STATUS_FULL;
        end else begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          held_bytes[front_pos] = req.data_byte;
          held_count++;
        end
      end
      bdq_pkg::REQ_PUSH_BACK: begin
        if (held_count >= DEPTH) begin
          rsp.status = bdq_pkg::STATUS_FULL;
        end else begin
          held_bytes[(front_pos + held_count) % DEPTH] = req.data_byte;
          held_count++;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (held_count == 0) begin
          rsp.status = bdq_pkg::STATUS_EMPTY;
        end else begin
          rsp.popped_byte = held_bytes[front_pos];
          front_pos = (front_pos + 1) % DEPTH;
          held_count--;
        end
      end
      bdq_pkg::REQ_POP_BACK: begin
        if (held_count == 0) begin
          rsp.status = bdq_pkg::STATUS_EMPTY;
        end else begin
          rsp.popped_byte = held_bytes[(front_pos + held_count - 1) % DEPTH];
          held_count--;
        end
      end
      bdq_pkg::REQ_DELETE_ALL: begin
        // compact the survivors towards the front, order kept
        keep = 0;
        for (int unsigned k = 0; k < held_count; k++) begin
          b = held_bytes[(front_pos + k) % DEPTH];
          if (b != req.data_byte) begin
            held_bytes[(front_pos + keep) % DEPTH] = b;
            keep++;
          end
        end
        rsp.removed_count = 7'(held_count - keep);
        held_count = keep;
      end
      default: begin
      end
    endcase
    rsp.occupancy_out = 7'(held_count);
    return rsp;
  endfunction

  // compare taken results, then predict for the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_pos  = 0;
      held_count = 0;
      predicted_rsp_q.delete();
      pending_count_o = 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (predicted_rsp_q.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          oldest_rsp = predicted_rsp_q[0];
          predicted_rsp_q.delete(0);
          check_field("status", rsp_i.status, oldest_rsp.status);
          check_field("popped_byte", rsp_i.popped_byte, oldest_rsp.popped_byte);
          check_field("removed_count", rsp_i.removed_count, oldest_rsp.removed_count);
          check_field("occupancy_out", rsp_i.occupancy_out, oldest_rsp.occupancy_out);
        end
      end
      if (req_valid_i && !req_stall_i) begin
        predicted_rsp_q = {predicted_rsp_q, apply_request(req_i)};
      end
      pending_count_o = predicted_rsp_q.size();
    end
  end

endmodule

@@ tb/byte_deque_with_delete_all_test.sv @@
`timescale 1ns / 1ps

module byte_deque_with_delete_all_test;

  localparam int unsigned DEPTH        = bdq_pkg::DefaultDepth;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // request codes the block treats as a size query
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // shape of a random stretch
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_e;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  bdq_pkg::req_t in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  bdq_pkg::rsp_t out_rsp_o;

  int unsigned   error_count;
  int unsigned   pending_count;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   random_sent;
  int unsigned   mix_len;
  int unsigned   pick;
  mix_e          mix;
  logic [2:0]    kind;
  logic [7:0]    value;

  byte_deque_with_delete_all #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  deque_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_stall_i    (in_stall_o),
    .req_i          (in_req_i),
    .rsp_valid_i    (out_valid_o),
    .rsp_stall_i    (out_stall_i),
    .rsp_i          (out_rsp_o),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("byte_deque_with_delete_all_test: errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // idle mix follows progress through the random part
  task automatic set_idle_mix(input int unsigned sent);
    case (sent * 3 / RANDOM_ITEMS)
      0: begin
        send_idle_pct = 17;
        recv_idle_pct = 62;
      end
      1: begin
        send_idle_pct = 62;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // present one request, entered and left at a falling edge
  task automatic send_req(input logic [2:0] req_kind, input logic [7:0] req_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{req_type: req_kind, data_byte: req_byte};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    set_idle_mix(0);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue cases, spare codes, extremes, deletes
    send_req(bdq_pkg::REQ_POP_FRONT, 8'h00);
    send_req(bdq_pkg::REQ_POP_BACK, 8'hFF);
    send_req(bdq_pkg::REQ_SIZE, 8'h00);
    send_req(bdq_pkg::REQ_DELETE_ALL, 8'h00);
    send_req(REQ_SPARE_LO, 8'hFF);
    send_req(REQ_SPARE_HI, 8'h5A);
    send_req(bdq_pkg::REQ_PUSH_BACK, 8'hFF);
    send_req(bdq_pkg::REQ_PUSH_FRONT, 8'h00);
    send_req(bdq_pkg::REQ_PUSH_BACK, 8'hAA);
    send_req(bdq_pkg::REQ_PUSH_FRONT, 8'hAA);
    send_req(bdq_pkg::REQ_PUSH_BACK, 8'h55);
    send_req(bdq_pkg::REQ_SIZE, 8'hFF);
    send_req(bdq_pkg::REQ_DELETE_ALL, 8'hAA);
    send_req(bdq_pkg::REQ_DELETE_ALL, 8'h12);
    send_req(bdq_pkg::REQ_POP_BACK, 8'h00);
    send_req(bdq_pkg::REQ_POP_FRONT, 8'h00);
    send_req(bdq_pkg::REQ_PUSH_FRONT, 8'h80);
    send_req(bdq_pkg::REQ_PUSH_BACK, 8'h01);
    send_req(bdq_pkg::REQ_DELETE_ALL, 8'hFF);
    send_req(bdq_pkg::REQ_POP_FRONT, 8'h00);
    send_req(bdq_pkg::REQ_POP_BACK, 8'h00);
    send_req(bdq_pkg::REQ_POP_BACK, 8'h00);
    send_req(bdq_pkg::REQ_DELETE_ALL, 8'h01);

    // random stretches: filling ones mostly push, draining ones mostly pop
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mix     = mix_e'($urandom_range(MIX_ANY, MIX_FILL));
      mix_len = $urandom_range(90, 20);
      for (int unsigned n = 0; n < mix_len && random_sent < RANDOM_ITEMS; n++) begin
        set_idle_mix(random_sent);
        pick = $urandom_range(99);
        case (mix)
          MIX_FILL: begin
            if (pick < 85)
              kind = $urandom_range(1) ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT;
            else if (pick < 92)
              kind = $urandom_range(1) ? bdq_pkg::REQ_POP_BACK : bdq_pkg::REQ_POP_FRONT;
            else if (pick < 96)
              kind = bdq_pkg::REQ_DELETE_ALL;
            else
              kind = 3'($urandom_range(REQ_SPARE_HI, bdq_pkg::REQ_SIZE));
          end
          MIX_DRAIN: begin
            if (pick < 75)
              kind = $urandom_range(1) ? bdq_pkg::REQ_POP_BACK : bdq_pkg::REQ_POP_FRONT;
            else if (pick < 85)
              kind = $urandom_range(1) ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT;
            else if (pick < 95)
              kind = bdq_pkg::REQ_DELETE_ALL;
            else
              kind = 3'($urandom_range(REQ_SPARE_HI, bdq_pkg::REQ_SIZE));
          end
          default: begin
            kind = 3'($urandom_range(7));
          end
        endcase
        // a narrow alphabet makes deletes hit several copies
        value = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        send_req(kind, value);
        random_sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then let the block settle
    while (pending_count != 0) @(negedge clk_i);
    repeat (DEPTH + 8) @(negedge clk_i);

    if (error_count == 0) begin
      $display("byte_deque_with_delete_all_test: clean");
    end else begin
      $display("byte_deque_with_delete_all_test: errors");
    end
    $finish;
  end

endmodule
